// ===== rtl/spr_pkg.sv =====
// Shared types and constants for the servo packet receiver with CRC-16 check.
// No dependencies; imported by spr_crc16_byte and the top level.
`timescale 1ns / 1ps
`default_nettype none

package spr_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] crc_t;
  typedef logic [15:0] pos_t;

  // CRC-16, not reflected, init zero, no final xor
  localparam crc_t CRC_POLY = 16'h8005;

  localparam pos_t MAX_LENGTH   = 16'd1024;
  localparam pos_t HEADER_BYTES = 16'd6;
  // largest length whose end position still fits in 16 bits
  localparam pos_t LEN_LIMIT    = 16'hFFFF - HEADER_BYTES;

  // fixed positions inside the header
  localparam pos_t POS_HEAD_ONE   = 16'd0;
  localparam pos_t POS_HEAD_TWO   = 16'd1;
  localparam pos_t POS_HEAD_THREE = 16'd2;
  localparam pos_t POS_STUFF      = 16'd3;
  localparam pos_t POS_LEN_LOW    = 16'd5;

  typedef enum logic [1:0] {
    STAT_RECEIVING = 2'd0,
    STAT_RESTART   = 2'd1,
    STAT_VALID     = 2'd2,
    STAT_CRC_BAD   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_HEAD_ONE   = 3'd0,
    REG_HEAD_TWO   = 3'd1,
    REG_HEAD_THREE = 3'd2,
    REG_STUFF      = 3'd3,
    REG_STUFF_EN   = 3'd4,
    REG_LOW_CRC_EN = 3'd5
  } reg_idx_t;

  localparam byte_t RST_HEAD_ONE   = 8'hFF;
  localparam byte_t RST_HEAD_TWO   = 8'hFF;
  localparam byte_t RST_HEAD_THREE = 8'hFD;
  localparam byte_t RST_STUFF      = 8'h00;

endpackage

`default_nettype wire

// ===== rtl/spr_crc16_byte.sv =====
// One-byte update of the CRC-16 (poly 0x8005, MSB first), purely combinational.
// Depends on spr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spr_crc16_byte (
  input  wire spr_pkg::crc_t  crc_in,
  input  wire spr_pkg::byte_t data,
  output spr_pkg::crc_t       crc_out
);
  import spr_pkg::*;

  crc_t r;

  always_comb begin
    r = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    crc_out = r;
  end

endmodule

`default_nettype wire

// ===== rtl/servo_packet_receiver_crc16_unit.sv =====
// Top level of the servo packet receiver: APB registers, deframing state,
// output register. Depends on spr_pkg and spr_crc16_byte.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------
//  input    | in_valid/in_ready  | rx_byte
//  output   | out_valid/out_ready| byte_value, byte_position, status
//  config   | APB psel/penable   | paddr, pwdata, prdata (pready = 1)
//
// One word per cycle: each byte is checked, fed through the CRC and
// loaded into the output register in the cycle it is accepted; its
// result is visible the next cycle. The byte CRC update is the longest
// path. in_ready is high while the output register is empty or being
// drained, so a full output register only stalls the input when the
// sink holds off. rst (synchronous) clears position, CRC, length and
// the output valid flag, and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module servo_packet_receiver_crc16_unit (
  input  wire                 clk,
  input  wire                 rst,
  // byte input
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire spr_pkg::byte_t rx_byte,
  // result output
  output logic                out_valid,
  input  wire                 out_ready,
  output spr_pkg::byte_t      byte_value,
  output spr_pkg::pos_t       byte_position,
  output logic [1:0]          status,
  // configuration
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire [4:0]           paddr,
  input  wire [31:0]          pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import spr_pkg::*;

  // configuration registers
  byte_t head_one, head_two, head_three, stuff_byte;
  logic  stuff_en, low_crc_en;

  // deframer state
  pos_t  pos_cnt, pos_cnt_next;
  crc_t  crc, crc_next;
  pos_t  len_val, len_val_next;
  byte_t len_low, len_low_next;
  byte_t prev_byte;

  crc_t    crc_fed;
  status_t status_next;
  logic    in_fire, cfg_write;
  reg_idx_t reg_idx;

  // per-byte decode helpers
  logic        hdr_bad, restart, feed;
  pos_t        len_cat;
  logic [16:0] end_pos, pos_plus2;

  assign pready    = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = reg_idx_t'(paddr[4:2]);

  spr_crc16_byte u_crc (
    .crc_in  (crc),
    .data    (rx_byte),
    .crc_out (crc_fed)
  );

  // ---- register file ----
  always_ff @(posedge clk) begin
    if (rst) begin
      head_one   <= RST_HEAD_ONE;
      head_two   <= RST_HEAD_TWO;
      head_three <= RST_HEAD_THREE;
      stuff_byte <= RST_STUFF;
      stuff_en   <= 1'b0;
      low_crc_en <= 1'b0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_HEAD_ONE:   head_one   <= pwdata[7:0];
        REG_HEAD_TWO:   head_two   <= pwdata[7:0];
        REG_HEAD_THREE: head_three <= pwdata[7:0];
        REG_STUFF:      stuff_byte <= pwdata[7:0];
        REG_STUFF_EN:   stuff_en   <= pwdata[0];
        REG_LOW_CRC_EN: low_crc_en <= pwdata[0];
        default: ;  // unmapped addresses ignore writes
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HEAD_ONE:   prdata = {24'd0, head_one};
      REG_HEAD_TWO:   prdata = {24'd0, head_two};
      REG_HEAD_THREE: prdata = {24'd0, head_three};
      REG_STUFF:      prdata = {24'd0, stuff_byte};
      REG_STUFF_EN:   prdata = {31'd0, stuff_en};
      REG_LOW_CRC_EN: prdata = {31'd0, low_crc_en};
      default:        prdata = 32'd0;
    endcase
  end

  // ---- per-byte decode ----
  always_comb begin
    len_cat   = {rx_byte, len_low};
    end_pos   = {1'b0, len_val} + {1'b0, HEADER_BYTES};
    pos_plus2 = {1'b0, pos_cnt} + 17'd2;

    hdr_bad = ((pos_cnt == POS_HEAD_ONE)   && (rx_byte != head_one))   ||
              ((pos_cnt == POS_HEAD_TWO)   && (rx_byte != head_two))   ||
              ((pos_cnt == POS_HEAD_THREE) && (rx_byte != head_three)) ||
              ((pos_cnt == POS_STUFF) && stuff_en && (rx_byte != stuff_byte));

    status_next  = STAT_RECEIVING;
    restart      = 1'b0;
    feed         = 1'b0;
    len_val_next = len_val;
    len_low_next = len_low;

    if (pos_cnt < HEADER_BYTES) begin
      if (hdr_bad) begin
        status_next = STAT_RESTART;
        restart     = 1'b1;
      end else begin
        feed = 1'b1;
        if (pos_cnt == POS_LEN_LOW) begin
          len_low_next = rx_byte;
        end
      end
    end else if (pos_cnt == HEADER_BYTES) begin
      // high length byte: range check, then feed unless it is the CRC low byte
      if ((len_cat > MAX_LENGTH) || (len_cat > LEN_LIMIT)) begin
        status_next = STAT_RESTART;
        restart     = 1'b1;
      end else begin
        len_val_next = len_cat;
        feed = pos_plus2 <= ({1'b0, len_cat} + {1'b0, HEADER_BYTES});
      end
    end else if ({1'b0, pos_cnt} == end_pos) begin
      // last byte is the CRC high byte; low byte came just before it
      restart = 1'b1;
      if ((rx_byte == crc[15:8]) && !(low_crc_en && (prev_byte != crc[7:0]))) begin
        status_next = STAT_VALID;
      end else begin
        status_next = STAT_CRC_BAD;
      end
    end else if ({1'b0, pos_cnt} > end_pos) begin
      // zero length runs past the end
      status_next = STAT_RESTART;
      restart     = 1'b1;
    end else begin
      feed = pos_plus2 <= end_pos;
    end

    if (restart) begin
      pos_cnt_next = '0;
      crc_next     = '0;
    end else begin
      pos_cnt_next = pos_cnt + 16'd1;
      crc_next     = feed ? crc_fed : crc;
    end
  end

  // ---- state update ----
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_cnt   <= '0;
      crc       <= '0;
      len_val   <= '0;
      len_low   <= '0;
      prev_byte <= '0;
    end else if (in_fire) begin
      pos_cnt   <= pos_cnt_next;
      crc       <= crc_next;
      len_val   <= len_val_next;
      len_low   <= len_low_next;
      prev_byte <= rx_byte;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_value    <= rx_byte;
      byte_position <= pos_cnt;
      status        <= status_next;
    end
  end

  // ---- assertions ----
  // a finished or aborted packet always restarts at position zero
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && (status_next != STAT_RECEIVING)) |=> (pos_cnt == '0))
    else $error("position not cleared after packet end or restart");

  // at position zero the CRC register holds its init value
  assert property (@(posedge clk) disable iff (rst)
    (pos_cnt == '0) |-> (crc == '0))
    else $error("CRC not cleared at packet start");

  // a byte still being received advances the position by one
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && (status_next == STAT_RECEIVING)) |=>
      (pos_cnt == $past(pos_cnt) + 16'd1))
    else $error("position did not advance");

  // the reported position is the one the byte was accepted at
  assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (out_valid && (byte_position == $past(pos_cnt))))
    else $error("result register not loaded with accepted byte");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for servo_packet_receiver_crc16_unit: directed framing cases and random
// packet traffic checked word by word against an in-bench deframer/CRC-16 tracker.
// Depends on spr_pkg and the RTL of the top level only.
`timescale 1ns / 1ps

module tb;
  import spr_pkg::*;

  // one checked output word
  typedef struct packed {
    byte_t   value;
    pos_t    position;
    status_t stat;
  } rx_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  byte_t       rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  byte_t       byte_value;
  pos_t        byte_position;
  logic [1:0]  status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  servo_packet_receiver_crc16_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .byte_value(byte_value), .byte_position(byte_position), .status(status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Register shadow: tracks what the block should hold after each write.
  // ---------------------------------------------------------------------
  byte_t cfg_head_one   = RST_HEAD_ONE;
  byte_t cfg_head_two   = RST_HEAD_TWO;
  byte_t cfg_head_three = RST_HEAD_THREE;
  byte_t cfg_stuff      = RST_STUFF;
  logic  cfg_stuff_en   = 1'b0;
  logic  cfg_low_crc_en = 1'b0;

  // Deframer tracking state, all zero after reset.
  pos_t  trk_pos     = '0;
  crc_t  trk_crc     = '0;
  pos_t  trk_len     = '0;
  byte_t trk_len_low = '0;
  byte_t trk_prev    = '0;

  rx_word_t due_words[$];   // words the block still owes, oldest first
  int       error_count = 0;
  int       word_count  = 0;  // accepted input words
  bit       valid_up    = 0;  // blocking copy of what in_valid was last set to
  bit       steady      = 0;  // no idling on either side while set
  int       hold_left   = 0;  // sink hold-off cycles still to run

  // CRC-16, poly 0x8005, MSB first, one byte
  function automatic crc_t crc16_byte(crc_t crc, byte_t b);
    crc_t r;
    int   k;
    r = crc ^ {b, 8'h00};
    for (k = 0; k < 8; k++)
      r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    return r;
  endfunction

  // Advance the deframer tracker by one accepted byte and queue the word
  // the block must produce for it.
  function automatic void track_deframe(byte_t c);
    int       n;
    int       len;
    int       last;
    bit       bad;
    bit       restart;
    bit       ok;
    rx_word_t w;
    n       = trk_pos;
    restart = 0;
    w.value    = c;
    w.position = trk_pos;
    w.stat     = STAT_RECEIVING;
    if (n < HEADER_BYTES) begin
      // header bytes; byte 4 is free, byte 5 is the length low half
      bad = (n == POS_HEAD_ONE   && c != cfg_head_one) ||
            (n == POS_HEAD_TWO   && c != cfg_head_two) ||
            (n == POS_HEAD_THREE && c != cfg_head_three) ||
            (n == POS_STUFF && cfg_stuff_en && c != cfg_stuff);
      if (bad) begin
        w.stat  = STAT_RESTART;
        restart = 1;
      end else begin
        trk_crc = crc16_byte(trk_crc, c);
        if (n == POS_LEN_LOW) trk_len_low = c;
      end
    end else if (n == HEADER_BYTES) begin
      len = {c, trk_len_low};
      if (len > MAX_LENGTH || len > LEN_LIMIT) begin
        w.stat  = STAT_RESTART;
        restart = 1;
      end else begin
        trk_len = pos_t'(len);
        // length high byte is in the CRC unless it doubles as CRC low (length one)
        if (n + 2 <= len + HEADER_BYTES) trk_crc = crc16_byte(trk_crc, c);
      end
    end else begin
      last = trk_len + HEADER_BYTES;
      if (n == last) begin
        // CRC high byte here, low byte was the one before
        ok = (c == trk_crc[15:8]) && (!cfg_low_crc_en || trk_prev == trk_crc[7:0]);
        w.stat  = ok ? STAT_VALID : STAT_CRC_BAD;
        restart = 1;
      end else if (n > last) begin
        // only reachable with length zero
        w.stat  = STAT_RESTART;
        restart = 1;
      end else if (n + 2 <= last) begin
        trk_crc = crc16_byte(trk_crc, c);
      end
    end
    if (restart) begin
      trk_pos = '0;
      trk_crc = '0;
    end else begin
      trk_pos = trk_pos + 16'd1;
    end
    trk_prev = c;
    due_words.push_back(w);
  endfunction

  // ---------------------------------------------------------------------
  // Output side: random stalls, hold-off on request, checking at negedge
  // (everything is stable there and the word is taken at the next edge).
  // ---------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 29);
      end
    end
  end

  always @(negedge clk) begin
    rx_word_t w;
    if (!rst && out_valid && out_ready) begin
      if (due_words.size() == 0) begin
        $error("unexpected word: value %0h position %0d status %0d",
               byte_value, byte_position, status);
        error_count++;
      end else begin
        w = due_words.pop_front();
        if (byte_value !== w.value) begin
          $error("byte_value: expected %0h, got %0h", w.value, byte_value);
          error_count++;
        end
        if (byte_position !== w.position) begin
          $error("byte_position: expected %0d, got %0d", w.position, byte_position);
          error_count++;
        end
        if (status !== w.stat) begin
          $error("status: expected %0d, got %0d", w.stat, status);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------
  // Offer one byte and hold it until taken; may idle a little afterwards.
  task automatic send_word(byte_t b);
    logic took;
    in_valid <= 1'b1;
    rx_byte  <= b;
    valid_up = 1;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    track_deframe(b);
    word_count++;
    if (!steady && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      valid_up = 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every owed word has come out.
  task automatic settle();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 0;
    end
    while (due_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write, setup then access; psel stays up across back-to-back writes
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_HEAD_ONE:   cfg_head_one   = val[7:0];
      REG_HEAD_TWO:   cfg_head_two   = val[7:0];
      REG_HEAD_THREE: cfg_head_three = val[7:0];
      REG_STUFF:      cfg_stuff      = val[7:0];
      REG_STUFF_EN:   cfg_stuff_en   = val[0];
      REG_LOW_CRC_EN: cfg_low_crc_en = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(byte_t h1, byte_t h2, byte_t h3, byte_t stuff,
                            logic stuff_en, logic low_en);
    write_reg(REG_HEAD_ONE, {24'd0, h1});
    write_reg(REG_HEAD_TWO, {24'd0, h2});
    write_reg(REG_HEAD_THREE, {24'd0, h3});
    write_reg(REG_STUFF, {24'd0, stuff});
    write_reg(REG_STUFF_EN, {31'd0, stuff_en});
    write_reg(REG_LOW_CRC_EN, {31'd0, low_en});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Build a packet for the current header settings with a correct CRC,
  // optionally flip one bit, and send the first 'keep' bytes (all if < 0).
  task automatic send_packet(int len, int flip, int keep);
    byte_t frame[$];
    crc_t  crc;
    int    i;
    pos_t  l;
    l = pos_t'(len);
    frame.push_back(cfg_head_one);
    frame.push_back(cfg_head_two);
    frame.push_back(cfg_head_three);
    frame.push_back(cfg_stuff_en ? cfg_stuff : byte_t'($urandom));
    frame.push_back(byte_t'($urandom));
    frame.push_back(l[7:0]);
    frame.push_back(l[15:8]);
    crc = '0;
    if (len <= MAX_LENGTH) begin
      for (i = 7; i <= len + 4; i++) frame.push_back(byte_t'($urandom));
      for (i = 0; i <= len + 4 && i < frame.size(); i++)
        crc = crc16_byte(crc, frame[i]);
    end
    // for length one the CRC low slot is the length high byte itself
    if (len >= 2) frame.push_back(crc[7:0]);
    frame.push_back(crc[15:8]);
    if (flip != 0) begin
      i = $urandom_range(frame.size() - 1);
      frame[i] = frame[i] ^ (8'h01 << $urandom_range(7));
    end
    if (keep < 0 || keep > frame.size()) keep = frame.size();
    for (i = 0; i < keep; i++) send_word(frame[i]);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // Header mismatch at positions 0, 1, 2 with reset defaults FF FF FD;
  // each bad byte must restart and not be looked at again.
  task automatic test_header_hunt();
    send_word(8'h00);
    send_word(8'hFF);
    send_word(8'h00);
    send_word(8'hFF);
    send_word(8'hFF);
    send_word(8'hFC);
  endtask

  // Length zero (byte 7 lies past the end), length one (CRC low slot is
  // the length high byte) and the largest length value (too long).
  task automatic test_length_edges();
    send_packet(0, 0, -1);
    send_packet(1, 0, -1);
    send_packet(16'hFFFF, 0, 7);
    settle();
  endtask

  // Mostly well-formed packets with random payloads; the rest corrupted,
  // truncated, too long, length zero or plain line noise.
  task automatic test_random_traffic(int words);
    int start;
    int pick;
    int len;
    int i;
    start = word_count;
    while (word_count - start < words) begin
      pick = $urandom_range(99);
      len  = ($urandom_range(99) < 70) ? $urandom_range(1, 12) : $urandom_range(13, 64);
      if (pick < 62) begin
        send_packet(len, 0, -1);
      end else if (pick < 77) begin
        send_packet(len, 1, -1);
      end else if (pick < 85) begin
        send_packet(len, 0, $urandom_range(1, len + 6));
      end else if (pick < 92) begin
        // noise, sometimes starting with a plausible first header byte
        for (i = $urandom_range(1, 6); i > 0; i--)
          send_word($urandom_range(3) == 0 ? cfg_head_one : byte_t'($urandom));
      end else if (pick < 96) begin
        send_packet($urandom_range(1) ? MAX_LENGTH + 1 :
                    $urandom_range(MAX_LENGTH + 1, 16'hFFFF), 0, 7);
      end else begin
        send_packet(0, 0, -1);
      end
    end
    settle();
  endtask

  // Sink holds off for a long stretch while the sender keeps offering,
  // so the output register fills and in_ready drops.
  task automatic test_sink_stall();
    hold_left = 250;
    send_packet(40, 0, -1);
    settle();
  endtask

  task automatic test_max_length();
    send_packet(MAX_LENGTH, 0, -1);
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_header_hunt();
    test_length_edges();

    // reset defaults
    test_random_traffic(50);

    // all-zero header, stuffing FF checked, both CRC bytes; no idling here
    set_config(8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1);
    steady = 1;
    test_random_traffic(50);
    steady = 0;

    // all-FF header, stuffing 00 checked, high CRC byte only
    set_config(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1, 1'b0);
    test_random_traffic(50);
    test_sink_stall();

    // random header, stuffing ignored, both CRC bytes
    set_config(byte_t'($urandom), byte_t'($urandom), byte_t'($urandom),
               byte_t'($urandom), 1'b0, 1'b1);
    test_random_traffic(60);
    test_max_length();

    settle();
    if (error_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #3_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
